### hw/rtl/cmd_pkg.sv
// ---------------------------------------------------------------------------
// Chunked message deframer package
// Shared types and framing constants for the deframer front end and queue.
// ---------------------------------------------------------------------------
package cmd_pkg;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_CHUNK0,
		PH_CHUNK1
	} phase_t;

	typedef enum logic [1:0] {
		ST_PAYLOAD   = 2'd0,
		ST_HDR_ERR   = 2'd1,
		ST_PAD_ERR   = 2'd2,
		ST_EMPTY_MSG = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_of_message;
		status_t    status;
	} result_t;

	localparam logic [7:0] PAD_MARK  = 8'hFF;
	localparam logic [7:0] SHORT_ANY = 8'hFF;
	localparam logic [7:0] SEG_FIRST = 8'd253;
	localparam logic [7:0] SEG_NEXT  = 8'd255;
	localparam logic [1:0] PREFIX_LEN = 2'd2;

endpackage

### hw/rtl/cmd_front.sv
// ---------------------------------------------------------------------------
// Deframer front end
// Accepts one received byte per cycle unless the queue is full, tracks
// header, segment and chunk framing, and queues payload and status results.
// ---------------------------------------------------------------------------
module cmd_front import cmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       queue_full,
	output logic       push_valid,
	output result_t    push_data
);

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_pos_q, hdr_pos_d;
	logic [7:0]  short_len_q, short_len_d;
	logic [7:0]  total_hi_q, total_hi_d;
	logic [15:0] bytes_rem_q, bytes_rem_d;
	logic [7:0]  seg_rem_q, seg_rem_d;
	logic [1:0]  prefix_rem_q, prefix_rem_d;

	logic        accept;
	logic        emit;
	result_t     res;
	logic [15:0] total;
	logic [7:0]  short_minus2;
	logic        hdr_ok;
	logic [15:0] bytes_dec;
	logic [7:0]  seg_dec;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	assign total        = {total_hi_q, rx_byte};
	assign short_minus2 = short_len_q - 8'd2;
	assign hdr_ok       = (total != 16'd0) && ((short_len_q == SHORT_ANY) ||
		((short_len_q >= 8'd2) && (total_hi_q == 8'd0) && (rx_byte == short_minus2)));
	assign bytes_dec    = bytes_rem_q - 16'd1;
	assign seg_dec      = seg_rem_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		hdr_pos_d    = hdr_pos_q;
		short_len_d  = short_len_q;
		total_hi_d   = total_hi_q;
		bytes_rem_d  = bytes_rem_q;
		seg_rem_d    = seg_rem_q;
		prefix_rem_d = prefix_rem_q;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_pos_q == 2'd0) begin
					short_len_d = rx_byte;
				end
				if (hdr_pos_q == 2'd2) begin
					total_hi_d = rx_byte;
				end
				if (hdr_pos_q != 2'd3) begin
					hdr_pos_d = hdr_pos_q + 2'd1;
				end else begin
					hdr_pos_d = 2'd0;
					if (hdr_ok) begin
						bytes_rem_d  = total;
						seg_rem_d    = (total > 16'(SEG_FIRST)) ? SEG_FIRST : total[7:0];
						prefix_rem_d = PREFIX_LEN;
						phase_d      = PH_DATA;
					end
				end
			end
			PH_CHUNK0: begin
				phase_d = PH_CHUNK1;
			end
			PH_CHUNK1: begin
				if (rx_byte != PAD_MARK) begin
					phase_d   = PH_HEADER;
					hdr_pos_d = 2'd0;
				end else begin
					seg_rem_d = (bytes_rem_q > 16'(SEG_NEXT)) ? SEG_NEXT : bytes_rem_q[7:0];
					phase_d   = PH_DATA;
				end
			end
			PH_DATA: begin
				bytes_rem_d = bytes_dec;
				seg_rem_d   = seg_dec;
				if (prefix_rem_q != 2'd0) begin
					prefix_rem_d = prefix_rem_q - 2'd1;
				end
				if (bytes_dec == 16'd0) begin
					phase_d   = PH_HEADER;
					hdr_pos_d = 2'd0;
				end else if (seg_dec == 8'd0) begin
					phase_d = PH_CHUNK0;
				end
			end
			default: begin
				phase_d   = PH_HEADER;
				hdr_pos_d = 2'd0;
			end
		endcase
	end

	always_comb begin
		emit                = 1'b0;
		res.payload_byte    = 8'd0;
		res.last_of_message = 1'b1;
		res.status          = ST_PAYLOAD;
		case (phase_q)
			PH_HEADER: begin
				if ((hdr_pos_q == 2'd3) && !hdr_ok) begin
					emit       = 1'b1;
					res.status = ST_HDR_ERR;
				end
			end
			PH_CHUNK1: begin
				if (rx_byte != PAD_MARK) begin
					emit       = 1'b1;
					res.status = ST_PAD_ERR;
				end
			end
			PH_DATA: begin
				if (prefix_rem_q != 2'd0) begin
					if (bytes_dec == 16'd0) begin
						emit       = 1'b1;
						res.status = ST_EMPTY_MSG;
					end
				end else begin
					emit                = 1'b1;
					res.payload_byte    = rx_byte;
					res.last_of_message = (bytes_dec == 16'd0);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push_valid = accept && emit;
	assign push_data  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_pos_q    <= 2'd0;
			short_len_q  <= 8'd0;
			total_hi_q   <= 8'd0;
			bytes_rem_q  <= 16'd0;
			seg_rem_q    <= 8'd0;
			prefix_rem_q <= PREFIX_LEN;
		end else if (accept) begin
			phase_q      <= phase_d;
			hdr_pos_q    <= hdr_pos_d;
			short_len_q  <= short_len_d;
			total_hi_q   <= total_hi_d;
			bytes_rem_q  <= bytes_rem_d;
			seg_rem_q    <= seg_rem_d;
			prefix_rem_q <= prefix_rem_d;
		end
	end

endmodule

### hw/rtl/cmd_queue.sv
// ---------------------------------------------------------------------------
// Deframer result queue
// Short first-in first-out queue that holds results until the output side
// takes them, so that the front end and the output stall independently.
// ---------------------------------------------------------------------------
module cmd_queue import cmd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  result_t push_data,
	output logic    full,
	output logic    pop_valid,
	input  logic    pop_stall,
	output result_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### hw/rtl/chunked_message_deframer_unit.sv
// A result is written into the result queue when the byte that causes it is accepted.
// One byte per cycle is accepted while the queue is not full; framing state updates per byte.
// The result queue of QUEUE_DEPTH entries stalls input only when it is full.
// Reset clears the framing state to wait for a header and empties the queue.
// ---------------------------------------------------------------------------
// Chunked message deframer unit
// Strips header, chunk framing and prefix from received bytes and delivers
// payload bytes and status results.
// ---------------------------------------------------------------------------
module chunked_message_deframer_unit import cmd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       last_of_message,
	output logic [1:0] status
);

	logic    queue_full;
	logic    push_valid;
	result_t push_data;
	result_t pop_data;

	cmd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.pop_valid  (out_valid),
		.pop_stall  (out_stall),
		.pop_data   (pop_data)
	);

	assign payload_byte    = pop_data.payload_byte;
	assign last_of_message = pop_data.last_of_message;
	assign status          = pop_data.status;

endmodule
